// ===== hdl/trcr_pkg.sv =====
`timescale 1ns / 1ps

package trcr_pkg;

  // Store geometry
  localparam int NUM_SLOTS      = 2;
  localparam int SLOT_BYTES     = 1024;
  localparam int WORDS_PER_SLOT = (SLOT_BYTES + 7) / 8;
  localparam int STORE_WORDS    = NUM_SLOTS * WORDS_PER_SLOT;
  localparam int ADDR_W         = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  // Widths of the fixed fields
  localparam int SLOT_W   = 4;   // read slot comes from a low nibble
  localparam int SIZE_W   = 11;
  localparam int MASK_W   = 2;
  localparam int SPAN_W   = 14;  // block*16+16 and the size cap
  localparam int BASE_W   = 16;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 2;

  // Presence bits that exist for the configured slot count
  localparam logic [MASK_W-1:0] SENSE_MASK = (NUM_SLOTS >= 2) ? 2'b11 : 2'b01;

  // Opcodes
  localparam logic [7:0] OP_ACTIVATE = 8'h41;
  localparam logic [7:0] OP_LED      = 8'h43;
  localparam logic [7:0] OP_QUERY    = 8'h4A;
  localparam logic [7:0] OP_SPEAKER  = 8'h4D;
  localparam logic [7:0] OP_READ     = 8'h51;
  localparam logic [7:0] OP_RESET    = 8'h52;
  localparam logic [7:0] OP_SENSE    = 8'h53;
  localparam logic [7:0] OP_STATUS56 = 8'h56;
  localparam logic [7:0] OP_WRITE    = 8'h57;

  // Argument that selects slot zero on a write
  localparam logic [7:0] WR_SLOT0_ARG = 8'h20;

  // Minimum report lengths
  localparam logic [8:0] LEN_LED   = 9'd4;
  localparam logic [8:0] LEN_SPK   = 9'd2;
  localparam logic [8:0] LEN_READ  = 9'd3;
  localparam logic [8:0] LEN_WRITE = 9'd19;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_PRESENT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOT0   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOT1   = 2'd2;

  typedef struct packed {
    logic [7:0]  command;
    logic [8:0]  report_length;
    logic [7:0]  first_argument;
    logic [7:0]  second_argument;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
  } trcr_cmd_t;

  typedef struct packed {
    logic [63:0] reply_word3;
    logic [63:0] reply_word2;
    logic [63:0] reply_word1;
    logic [63:0] reply_word0;
  } trcr_reply_t;

  typedef struct packed {
    logic [MASK_W-1:0] slot_present_mask;
    logic [SIZE_W-1:0] slot0_bytes;
    logic [SIZE_W-1:0] slot1_bytes;
  } trcr_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_cmd;    // latch the accepted command
    logic mem_en;      // access the slot store
    logic mem_half;    // which word of the 16-byte block
    logic save_lo;     // keep the first read word
    logic load_reply;  // register the reply and its strobe
  } trcr_ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic xfer;        // command moves a block through the store
  } trcr_stat_t;

endpackage

// ===== hdl/trcr_regs.sv =====
`timescale 1ns / 1ps

module trcr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [trcr_pkg::PADDR_W-1:0]   paddr,
  input  logic [trcr_pkg::PDATA_W-1:0]   pwdata,
  output logic [trcr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output trcr_pkg::trcr_cfg_t            cfg_o
);

  trcr_pkg::trcr_cfg_t cfg_q;
  logic [trcr_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[trcr_pkg::PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Take register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        trcr_pkg::REG_PRESENT: begin
          cfg_q.slot_present_mask <= pwdata[trcr_pkg::MASK_W-1:0];
        end
        trcr_pkg::REG_SLOT0: begin
          cfg_q.slot0_bytes <= pwdata[trcr_pkg::SIZE_W-1:0];
        end
        trcr_pkg::REG_SLOT1: begin
          cfg_q.slot1_bytes <= pwdata[trcr_pkg::SIZE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      trcr_pkg::REG_PRESENT: prdata = trcr_pkg::PDATA_W'(cfg_q.slot_present_mask);
      trcr_pkg::REG_SLOT0:   prdata = trcr_pkg::PDATA_W'(cfg_q.slot0_bytes);
      trcr_pkg::REG_SLOT1:   prdata = trcr_pkg::PDATA_W'(cfg_q.slot1_bytes);
      default:               prdata = '0;
    endcase
  end

endmodule

// ===== hdl/trcr_ctrl.sv =====
`timescale 1ns / 1ps

module trcr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  trcr_pkg::trcr_stat_t  stat_i,
  output trcr_pkg::trcr_ctrl_t  ctrl_o,
  output logic                  busy_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_XFER0 = 4'b0010,
    ST_XFER1 = 4'b0100,
    ST_RESP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Advance through the store accesses, skip them when nothing moves
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.load_cmd = 1'b1;
          state_d         = ST_XFER0;
        end
      end
      ST_XFER0: begin
        if (stat_i.xfer) begin
          ctrl_o.mem_en = 1'b1;
          state_d       = ST_XFER1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_XFER1: begin
        ctrl_o.mem_en   = 1'b1;
        ctrl_o.mem_half = 1'b1;
        ctrl_o.save_lo  = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        ctrl_o.load_reply = 1'b1;
        state_d           = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== hdl/trcr_dp.sv =====
`timescale 1ns / 1ps

module trcr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trcr_pkg::trcr_cmd_t   cmd_i,
  input  trcr_pkg::trcr_cfg_t   cfg_i,
  input  trcr_pkg::trcr_ctrl_t  ctrl_i,
  output trcr_pkg::trcr_stat_t  stat_o,
  output trcr_pkg::trcr_reply_t reply_o,
  output logic                  reply_valid_o
);

  localparam int AW = trcr_pkg::ADDR_W;
  localparam int BW = trcr_pkg::BASE_W;
  localparam int SW = trcr_pkg::SPAN_W;

  trcr_pkg::trcr_cmd_t   cmd_q;
  trcr_pkg::trcr_reply_t reply_q;
  logic                  reply_valid_q;

  logic [63:0]   mem_q [trcr_pkg::STORE_WORDS];
  logic [trcr_pkg::STORE_WORDS-1:0] valid_q;
  logic [63:0]   rdata_q;
  logic          rvalid_q;
  logic [63:0]   lo_q;

  logic          is_read, is_write, long_rd, long_wr;
  logic [trcr_pkg::SLOT_W-1:0] slot;
  logic          usable, fits;
  logic [trcr_pkg::SIZE_W-1:0] size;
  logic [SW-1:0] size_w, size_cap, span;
  logic [BW-1:0] base;
  logic [AW-1:0] addr;
  logic [63:0]   wdata;
  logic [63:0]   rd_word0, rd_word1;
  logic          mem_wr, mem_rd;
  logic [255:0]  rb;
  logic          reply;

  // Latch the accepted command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_cmd) begin
      cmd_q <= cmd_i;
    end
  end

  // Decode slot, presence and block range
  assign is_read  = (cmd_q.command == trcr_pkg::OP_READ);
  assign is_write = (cmd_q.command == trcr_pkg::OP_WRITE);
  assign long_rd  = (cmd_q.report_length >= trcr_pkg::LEN_READ);
  assign long_wr  = (cmd_q.report_length >= trcr_pkg::LEN_WRITE);

  always_comb begin
    if (is_write) begin
      slot = (cmd_q.first_argument == trcr_pkg::WR_SLOT0_ARG) ? 4'd0 : 4'd1;
    end else begin
      slot = cmd_q.first_argument[trcr_pkg::SLOT_W-1:0];
    end
  end

  assign usable = (32'(slot) < trcr_pkg::NUM_SLOTS) && (slot < 4'd2)
                  && cfg_i.slot_present_mask[slot[0]];

  assign size     = slot[0] ? cfg_i.slot1_bytes : cfg_i.slot0_bytes;
  assign size_w   = SW'(size);
  assign size_cap = (size_w > SW'(trcr_pkg::SLOT_BYTES)) ? SW'(trcr_pkg::SLOT_BYTES)
                                                        : size_w;
  assign span     = SW'({cmd_q.second_argument, 4'b0000}) + SW'(16);
  assign fits     = (span <= size_cap);

  assign stat_o.xfer = ((is_read && long_rd) || (is_write && long_wr)) && usable && fits;

  // Word address of the block half
  assign base  = BW'(slot) * BW'(trcr_pkg::WORDS_PER_SLOT)
                 + BW'({cmd_q.second_argument, 1'b0});
  assign addr  = AW'(base + BW'(ctrl_i.mem_half));
  assign wdata = ctrl_i.mem_half ? cmd_q.payload_high : cmd_q.payload_low;
  assign mem_wr = ctrl_i.mem_en && is_write;
  assign mem_rd = ctrl_i.mem_en && !is_write;

  // Slot store
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem_q[addr] <= wdata;
    end
    if (mem_rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Written marks: an unwritten word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (mem_wr) begin
        valid_q[addr] <= 1'b1;
      end
      if (mem_rd) begin
        rvalid_q <= valid_q[addr];
      end
    end
  end

  // Hold the first read word while the second is fetched
  always_ff @(posedge clk_i) begin
    if (ctrl_i.save_lo) begin
      lo_q <= rvalid_q ? rdata_q : 64'd0;
    end
  end

  assign rd_word0 = fits ? lo_q : 64'd0;
  assign rd_word1 = (fits && rvalid_q) ? rdata_q : 64'd0;

  // Assemble the reply bytes
  always_comb begin
    rb    = '0;
    reply = 1'b0;
    unique case (cmd_q.command)
      trcr_pkg::OP_ACTIVATE: begin
        rb[31:0] = 32'h77FF0141;
        reply    = 1'b1;
      end
      trcr_pkg::OP_LED: begin
        if (cmd_q.report_length >= trcr_pkg::LEN_LED) begin
          rb[31:0] = {cmd_q.payload_low[7:0], cmd_q.second_argument,
                      cmd_q.first_argument, trcr_pkg::OP_LED};
          reply    = 1'b1;
        end
      end
      trcr_pkg::OP_QUERY: begin
        rb[7:0] = trcr_pkg::OP_QUERY;
        reply   = 1'b1;
      end
      trcr_pkg::OP_SPEAKER: begin
        rb[7:0]  = trcr_pkg::OP_SPEAKER;
        rb[15:8] = ((cmd_q.report_length >= trcr_pkg::LEN_SPK)
                    && (cmd_q.first_argument != 8'd0)) ? 8'h01 : 8'h00;
        reply    = 1'b1;
      end
      trcr_pkg::OP_RESET: begin
        rb[39:0] = 40'h08050A0252;
        reply    = 1'b1;
      end
      trcr_pkg::OP_SENSE: begin
        rb[7:0]   = trcr_pkg::OP_SENSE;
        rb[15:8]  = 8'(cfg_i.slot_present_mask & trcr_pkg::SENSE_MASK);
        rb[55:48] = 8'h01;
        reply     = 1'b1;
      end
      trcr_pkg::OP_STATUS56: begin
        rb[7:0] = trcr_pkg::OP_STATUS56;
        reply   = 1'b1;
      end
      trcr_pkg::OP_READ: begin
        if (long_rd && usable) begin
          rb[7:0]    = trcr_pkg::OP_READ;
          rb[15:8]   = 8'h10 + 8'(slot);
          rb[23:16]  = cmd_q.second_argument;
          rb[87:24]  = rd_word0;
          rb[151:88] = rd_word1;
          reply      = 1'b1;
        end
      end
      trcr_pkg::OP_WRITE: begin
        if (long_wr && usable) begin
          rb[7:0]    = trcr_pkg::OP_WRITE;
          rb[15:8]   = 8'h10 + 8'(slot);
          rb[23:16]  = cmd_q.second_argument;
          rb[87:24]  = cmd_q.payload_low;
          rb[151:88] = cmd_q.payload_high;
          reply      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (cmd_q.report_length == 9'd0) begin
      reply = 1'b0;
    end
  end

  // Register the reply words
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_reply) begin
      reply_q.reply_word0 <= rb[63:0];
      reply_q.reply_word1 <= rb[127:64];
      reply_q.reply_word2 <= rb[191:128];
      reply_q.reply_word3 <= rb[255:192];
    end
  end

  // One-cycle strobe for the reply transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_valid_q <= 1'b0;
    end else begin
      reply_valid_q <= ctrl_i.load_reply && reply;
    end
  end

  assign reply_o       = reply_q;
  assign reply_valid_o = reply_valid_q;

endmodule

// ===== hdl/tag_reader_command_responder.sv =====
`timescale 1ns / 1ps

// Tag reader command responder.
// Command channel: drive cmd_i and raise start; the command is taken at the
// rising edge where start is high and busy is low. busy stays high until the
// block can take the next command.
// Reply channel: reply_o is valid for exactly one cycle while reply_valid_o is
// high; commands that earn no reply give no strobe. The receiver cannot stall.
// Sequence: after acceptance the controller passes through XFER0 and RESP for
// replies without a block transfer, and through XFER0, XFER1 and RESP for a read
// or write that reaches the slot store, which moves its two 64-bit words through
// one store port, one word per cycle. The strobe is registered in RESP. busy stays
// high until the reply register is loaded, so no new command is taken meanwhile.
// Configuration: APB registers at byte addresses 0 (presence mask), 4 (slot
// zero size) and 8 (slot one size); write them only while idle.
// Reset clears the registers, the controller and the per-word written marks,
// so the slot store reads as zero at once; no clearing pass is needed.
module tag_reader_command_responder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  trcr_pkg::trcr_cmd_t                 cmd_i,
  output trcr_pkg::trcr_reply_t               reply_o,
  output logic                                reply_valid_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [trcr_pkg::PADDR_W-1:0]        paddr,
  input  logic [trcr_pkg::PDATA_W-1:0]        pwdata,
  output logic [trcr_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  trcr_pkg::trcr_cfg_t  cfg;
  trcr_pkg::trcr_ctrl_t ctrl;
  trcr_pkg::trcr_stat_t stat;

  trcr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  trcr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  trcr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .cfg_i         (cfg),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .reply_o       (reply_o),
    .reply_valid_o (reply_valid_o)
  );

endmodule

// ===== hdl/trcr_checker.sv =====
`timescale 1ns / 1ps

module trcr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic reply_valid_o,
  input logic pready
);

  // An accepted command always occupies the block for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command transfer");

  // One command gives at most one reply, and commands are spaced apart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o |=> !reply_valid_o)
    else $error("reply strobe held for more than one cycle");

  // The reply comes out as the controller returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o |-> !busy)
    else $error("reply strobe while busy");

  // A reply always ends a busy spell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o |-> $past(busy))
    else $error("reply strobe without a preceding busy cycle");

  // The register port never inserts wait states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind tag_reader_command_responder trcr_checker u_trcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .reply_valid_o (reply_valid_o),
  .pready        (pready)
);
